/* rtl/gjsi_pkg.sv */
// Shared constants, command/status types and fixed-point helpers for the
// Gauss-Jordan solver. No dependencies.
`default_nettype none

package gjsi_pkg;

    localparam int MAX_N     = 16;
    localparam int N_W       = $clog2(MAX_N);
    localparam int IDX_W     = N_W + 1;
    localparam int VW        = 48;
    localparam int HW        = VW / 2;
    localparam int FRAC_BITS = 24;
    localparam int ADDR_W    = 2 + 2 * N_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int DIV_STEPS = VW + FRAC_BITS;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_SOLVE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // storage regions inside the shared element RAM
    localparam logic [1:0] SEL_COEF = 2'd0;
    localparam logic [1:0] SEL_INV  = 2'd1;
    localparam logic [1:0] SEL_RHS  = 2'd2;

    localparam logic [2:0] SRC_IN  = 3'd0;
    localparam logic [2:0] SRC_DIV = 3'd1;
    localparam logic [2:0] SRC_SUB = 3'd2;
    localparam logic [2:0] SRC_RD  = 3'd3;
    localparam logic [2:0] SRC_A   = 3'd4;

    localparam logic signed [VW-1:0] FX_ONE =
        {{(VW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              rd_ident;
        logic              rd_diag;
        logic              rd_zero;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [2:0]        wr_src;
        logic              piv_init;
        logic              piv_cmp;
        logic [N_W-1:0]    piv_idx;
        logic              div_start;
        logic              ld_a;
        logic              ld_f;
        logic              mul_start;
        logic              out_ld_read;
        logic              out_ld_solve;
        logic              out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic [N_W-1:0] piv_row;
        logic           piv_zero;
        logic           div_done;
        logic           mul_done;
    } dp_stat_t;

    function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
        return v[VW-1] ? VW'(-v) : VW'(v);
    endfunction

    // signed result from a magnitude, saturating at the 48-bit range
    function automatic logic signed [VW-1:0] sat_mag(input logic [2*VW-1:0] m,
                                                     input logic neg);
        logic signed [VW-1:0] r;
        if (|m[2*VW-1:VW-1]) begin
            r = neg ? VMIN : VMAX;
        end else begin
            r = neg ? -$signed(m[VW-1:0]) : $signed(m[VW-1:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/gjsi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gjsi_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/gjsi_div.sv */
// Bit-serial restoring fixed-point divider, one quotient bit a cycle.
// Depends on gjsi_pkg.
`default_nettype none

module gjsi_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic signed [gjsi_pkg::VW-1:0] dividend,
    input  wire logic signed [gjsi_pkg::VW-1:0] divisor,
    output logic                               done,
    output logic signed [gjsi_pkg::VW-1:0]     quot
);
    import gjsi_pkg::*;

    localparam logic [VW+1:0] MAGLIM = (VW+2)'(1) << (VW - 1);

    logic [DCNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIV_STEPS-1:0]   sh_reg, sh_next;
    logic [VW-1:0]          d_reg, d_next;
    logic [VW-1:0]          r_reg, r_next;
    logic [VW:0]            q_reg, q_next;
    logic                   neg_reg, neg_next;
    logic                   done_reg, done_next;
    logic [VW:0]            r1;
    logic                   ge;
    logic [VW+1:0]          q1;

    always_comb begin
        r1 = {r_reg, sh_reg[DIV_STEPS-1]};
        ge = r1 >= {1'b0, d_reg};
        q1 = {q_reg, ge};
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        done_next = done_reg;
        if (start) begin
            cnt_next  = DCNT_W'(DIV_STEPS);
            sh_next   = {mag(dividend), {FRAC_BITS{1'b0}}};
            d_next    = mag(divisor);
            r_next    = '0;
            q_next    = '0;
            neg_next  = dividend[VW-1] ^ divisor[VW-1];
            done_next = 1'b0;
        end else if (cnt_reg != '0) begin
            sh_next = sh_reg << 1;
            r_next  = ge ? VW'(r1 - {1'b0, d_reg}) : VW'(r1);
            // clamp the running quotient once it passes the range
            q_next  = (q1 > MAGLIM) ? MAGLIM[VW:0] : q1[VW:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        sh_reg  <= sh_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = sat_mag((2*VW)'(q_reg), neg_reg);

endmodule

`default_nettype wire

/* rtl/gjsi_dpath.sv */
// Datapath: element RAM, pivot search, divider, sequential multiplier,
// saturating subtract and the result register. Depends on gjsi_pkg,
// gjsi_ram and gjsi_div.
`default_nettype none

module gjsi_dpath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire gjsi_pkg::dp_cmd_t             cmd,
    input  wire logic signed [gjsi_pkg::VW-1:0] in_value,
    output gjsi_pkg::dp_stat_t                 stat,
    output logic signed [gjsi_pkg::VW-1:0]     out_data,
    output logic                               out_status
);
    import gjsi_pkg::*;

    logic [VW-1:0]        ram_q;
    logic signed [VW-1:0] rd_val;
    logic signed [VW-1:0] wdata;
    logic                 rd_ident_reg, rd_diag_reg, rd_zero_reg;

    logic signed [VW-1:0] a_reg, f_reg;
    logic [VW-1:0]        best_mag_reg;
    logic signed [VW-1:0] best_val_reg;
    logic [N_W-1:0]       best_row_reg;

    logic                 div_done;
    logic signed [VW-1:0] div_q;

    logic [2:0]           mstep_reg;
    logic [VW-1:0]        mx_reg, my_reg;
    logic                 mneg_reg;
    logic [VW-1:0]        pp_reg;
    logic [1:0]           psh_reg;
    logic [2*VW-1:0]      acc_reg;
    logic signed [VW-1:0] prod_reg;
    logic [1:0]           pidx;
    logic [HW-1:0]        xh, yh;

    logic signed [VW:0]   diff;
    logic signed [VW-1:0] sub_val;

    logic signed [VW-1:0] out_data_reg;
    logic                 out_status_reg;

    gjsi_ram #(
        .WIDTH (VW),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (cmd.wr_addr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (ram_q)
    );

    gjsi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (rd_val),
        .divisor  (best_val_reg),
        .done     (div_done),
        .quot     (div_q)
    );

    // inverse entries not yet written since solve start read as identity
    always_comb begin
        if (rd_zero_reg) begin
            rd_val = '0;
        end else if (rd_ident_reg) begin
            rd_val = rd_diag_reg ? FX_ONE : '0;
        end else begin
            rd_val = $signed(ram_q);
        end
    end

    always_comb begin
        diff = {a_reg[VW-1], a_reg} - {prod_reg[VW-1], prod_reg};
        if (diff[VW] != diff[VW-1]) begin
            sub_val = diff[VW] ? VMIN : VMAX;
        end else begin
            sub_val = diff[VW-1:0];
        end
    end

    always_comb begin
        unique case (cmd.wr_src)
            SRC_IN:  wdata = in_value;
            SRC_DIV: wdata = div_q;
            SRC_SUB: wdata = sub_val;
            SRC_RD:  wdata = rd_val;
            SRC_A:   wdata = a_reg;
            default: wdata = '0;
        endcase
    end

    assign pidx = 2'(mstep_reg - 3'd1);
    assign xh   = pidx[0] ? mx_reg[VW-1:HW] : mx_reg[HW-1:0];
    assign yh   = pidx[1] ? my_reg[VW-1:HW] : my_reg[HW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mstep_reg    <= '0;
            rd_ident_reg <= 1'b0;
            rd_diag_reg  <= 1'b0;
            rd_zero_reg  <= 1'b0;
        end else begin
            rd_ident_reg <= cmd.rd_ident;
            rd_diag_reg  <= cmd.rd_diag;
            rd_zero_reg  <= cmd.rd_zero;
            if (cmd.mul_start) begin
                mstep_reg <= 3'd1;
            end else if (mstep_reg != '0 && mstep_reg != 3'd7) begin
                mstep_reg <= mstep_reg + 3'd1;
            end
        end

        if (cmd.ld_a) begin
            a_reg <= rd_val;
        end
        if (cmd.ld_f) begin
            f_reg <= rd_val;
        end

        if (cmd.piv_init) begin
            best_mag_reg <= '0;
            best_val_reg <= '0;
            best_row_reg <= cmd.piv_idx;
        end else if (cmd.piv_cmp && mag(rd_val) > best_mag_reg) begin
            best_mag_reg <= mag(rd_val);
            best_val_reg <= rd_val;
            best_row_reg <= cmd.piv_idx;
        end

        // four 24x24 partial products, each registered and added in the cycle after it is formed
        if (cmd.mul_start) begin
            mx_reg   <= mag(f_reg);
            my_reg   <= mag(rd_val);
            mneg_reg <= f_reg[VW-1] ^ rd_val[VW-1];
            acc_reg  <= '0;
        end else begin
            if (mstep_reg >= 3'd1 && mstep_reg <= 3'd4) begin
                pp_reg  <= xh * yh;
                psh_reg <= 2'(pidx[0]) + 2'(pidx[1]);
            end
            if (mstep_reg >= 3'd2 && mstep_reg <= 3'd5) begin
                acc_reg <= acc_reg + ((2*VW)'(pp_reg) << (HW * int'(psh_reg)));
            end
            if (mstep_reg == 3'd6) begin
                prod_reg <= sat_mag(acc_reg >> FRAC_BITS, mneg_reg);
            end
        end

        if (cmd.out_ld_read) begin
            out_data_reg   <= rd_val;
            out_status_reg <= 1'b0;
        end else if (cmd.out_ld_solve) begin
            out_data_reg   <= '0;
            out_status_reg <= cmd.out_status;
        end
    end

    assign stat.piv_row  = best_row_reg;
    assign stat.piv_zero = (best_mag_reg == '0);
    assign stat.div_done = div_done;
    assign stat.mul_done = (mstep_reg == 3'd7);

    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

/* rtl/gjsi_ctrl.sv */
// Controller: request handshake, matrix size register, solve sequencer and
// the valid bits of the inverse region. Depends on gjsi_pkg.
`default_nettype none

module gjsi_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [1:0]         in_req,
    input  wire logic [3:0]         in_row,
    input  wire logic [4:0]         in_col,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire logic               cfg_we,
    input  wire logic [4:0]         cfg_wdata,
    output gjsi_pkg::dp_cmd_t       cmd,
    input  wire gjsi_pkg::dp_stat_t stat
);
    import gjsi_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_HREAD   = 5'd1;
    localparam logic [4:0] S_INIT    = 5'd2;
    localparam logic [4:0] S_PV_RD   = 5'd3;
    localparam logic [4:0] S_PV_CMP  = 5'd4;
    localparam logic [4:0] S_PV_CHK  = 5'd5;
    localparam logic [4:0] S_SW_RA   = 5'd6;
    localparam logic [4:0] S_SW_RB   = 5'd7;
    localparam logic [4:0] S_SW_WA   = 5'd8;
    localparam logic [4:0] S_SW_WB   = 5'd9;
    localparam logic [4:0] S_NM_RD   = 5'd10;
    localparam logic [4:0] S_NM_DIV  = 5'd11;
    localparam logic [4:0] S_NM_WAIT = 5'd12;
    localparam logic [4:0] S_NM_WR   = 5'd13;
    localparam logic [4:0] S_EL_F    = 5'd14;
    localparam logic [4:0] S_EL_FL   = 5'd15;
    localparam logic [4:0] S_EL_RX   = 5'd16;
    localparam logic [4:0] S_EL_RY   = 5'd17;
    localparam logic [4:0] S_EL_MUL  = 5'd18;
    localparam logic [4:0] S_EL_MW   = 5'd19;
    localparam logic [4:0] S_EL_WR   = 5'd20;
    localparam logic [4:0] S_NEXT    = 5'd21;
    localparam logic [4:0] S_DONE    = 5'd22;

    logic [4:0]           state_reg, state_next;
    logic [4:0]           size_reg;
    logic [IDX_W-1:0]     i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [1:0]           sel_reg, sel_next;
    logic [N_W-1:0]       p_reg, p_next;
    logic                 sing_reg, sing_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MAX_N*MAX_N-1:0] inv_valid_reg;

    logic [IDX_W-1:0]     n_eff;
    logic [N_W-1:0]       ix, jx, kx, rw;
    logic                 out_free;
    logic                 accept;
    logic [1:0]           rsel, wsel;
    logic [N_W-1:0]       rrow, rcol, wrow, wcol;
    logic                 step_end;
    logic [IDX_W-1:0]     step_j;
    logic [1:0]           step_sel;

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [1:0] sel,
                                                    input logic [N_W-1:0] r,
                                                    input logic [N_W-1:0] c);
        return (sel == SEL_RHS) ? {sel, r, {N_W{1'b0}}} : {sel, r, c};
    endfunction

    always_comb begin
        if (size_reg == '0) begin
            n_eff = IDX_W'(1);
        end else if (int'(size_reg) > MAX_N) begin
            n_eff = IDX_W'(MAX_N);
        end else begin
            n_eff = IDX_W'(size_reg);
        end
    end

    assign ix       = i_reg[N_W-1:0];
    assign jx       = j_reg[N_W-1:0];
    assign kx       = k_reg[N_W-1:0];
    assign rw       = N_W'(in_row);
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // walk coef then inverse entry of each column, then the right-hand side
    always_comb begin
        step_end = (sel_reg == SEL_RHS);
        step_j   = j_reg;
        step_sel = sel_reg;
        if (sel_reg == SEL_COEF) begin
            step_sel = SEL_INV;
        end else if (sel_reg == SEL_INV) begin
            if (j_reg + 1'b1 < n_eff) begin
                step_j   = j_reg + 1'b1;
                step_sel = SEL_COEF;
            end else begin
                step_sel = SEL_RHS;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        sel_next       = sel_reg;
        p_next         = p_reg;
        sing_next      = sing_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        rsel           = SEL_COEF;
        rrow           = '0;
        rcol           = '0;
        wsel           = SEL_COEF;
        wrow           = '0;
        wcol           = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_req)
                        REQ_WRITE: begin
                            wrow = rw;
                            wcol = N_W'(in_col);
                            cmd.wr_src = SRC_IN;
                            if (int'(in_col) < MAX_N) begin
                                wsel = SEL_COEF;
                                cmd.wr_en = 1'b1;
                            end else if (int'(in_col) == MAX_N) begin
                                wsel = SEL_RHS;
                                cmd.wr_en = 1'b1;
                            end
                        end
                        REQ_SOLVE: begin
                            state_next = S_INIT;
                        end
                        REQ_READ: begin
                            rrow = rw;
                            rcol = N_W'(in_col);
                            cmd.rd_en = 1'b1;
                            if (int'(in_col) < MAX_N) begin
                                rsel = SEL_INV;
                            end else if (int'(in_col) == MAX_N) begin
                                rsel = SEL_RHS;
                            end else begin
                                cmd.rd_zero = 1'b1;
                            end
                            state_next = S_HREAD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_HREAD: begin
                cmd.out_ld_read = 1'b1;
                out_valid_next  = 1'b1;
                state_next      = S_IDLE;
            end
            S_INIT: begin
                sing_next  = 1'b0;
                i_next     = '0;
                j_next     = '0;
                state_next = S_PV_RD;
            end
            S_PV_RD: begin
                rsel = SEL_COEF;
                rrow = jx;
                rcol = ix;
                cmd.rd_en = 1'b1;
                cmd.piv_init = (j_reg == i_reg);
                cmd.piv_idx  = ix;
                state_next = S_PV_CMP;
            end
            S_PV_CMP: begin
                cmd.piv_cmp = 1'b1;
                cmd.piv_idx = jx;
                if (j_reg + 1'b1 < n_eff) begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_PV_RD;
                end else begin
                    state_next = S_PV_CHK;
                end
            end
            S_PV_CHK: begin
                p_next   = stat.piv_row;
                j_next   = '0;
                sel_next = SEL_COEF;
                if (stat.piv_zero) begin
                    sing_next  = 1'b1;
                    state_next = S_DONE;
                end else if (stat.piv_row == ix) begin
                    state_next = S_NM_RD;
                end else begin
                    state_next = S_SW_RA;
                end
            end
            S_SW_RA: begin
                rsel = sel_reg;
                rrow = ix;
                rcol = jx;
                cmd.rd_en = 1'b1;
                state_next = S_SW_RB;
            end
            S_SW_RB: begin
                cmd.ld_a = 1'b1;
                rsel = sel_reg;
                rrow = p_reg;
                rcol = jx;
                cmd.rd_en = 1'b1;
                state_next = S_SW_WA;
            end
            S_SW_WA: begin
                wsel = sel_reg;
                wrow = ix;
                wcol = jx;
                cmd.wr_en  = 1'b1;
                cmd.wr_src = SRC_RD;
                state_next = S_SW_WB;
            end
            S_SW_WB: begin
                wsel = sel_reg;
                wrow = p_reg;
                wcol = jx;
                cmd.wr_en  = 1'b1;
                cmd.wr_src = SRC_A;
                if (step_end) begin
                    j_next     = '0;
                    sel_next   = SEL_COEF;
                    state_next = S_NM_RD;
                end else begin
                    j_next     = step_j;
                    sel_next   = step_sel;
                    state_next = S_SW_RA;
                end
            end
            S_NM_RD: begin
                rsel = sel_reg;
                rrow = ix;
                rcol = jx;
                cmd.rd_en = 1'b1;
                state_next = S_NM_DIV;
            end
            S_NM_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = S_NM_WAIT;
            end
            S_NM_WAIT: begin
                if (stat.div_done) begin
                    state_next = S_NM_WR;
                end
            end
            S_NM_WR: begin
                wsel = sel_reg;
                wrow = ix;
                wcol = jx;
                cmd.wr_en  = 1'b1;
                cmd.wr_src = SRC_DIV;
                if (step_end) begin
                    k_next     = '0;
                    state_next = S_EL_F;
                end else begin
                    j_next     = step_j;
                    sel_next   = step_sel;
                    state_next = S_NM_RD;
                end
            end
            S_EL_F: begin
                if (k_reg >= n_eff) begin
                    state_next = S_NEXT;
                end else if (k_reg == i_reg) begin
                    k_next = k_reg + 1'b1;
                end else begin
                    rsel = SEL_COEF;
                    rrow = kx;
                    rcol = ix;
                    cmd.rd_en  = 1'b1;
                    j_next     = '0;
                    sel_next   = SEL_COEF;
                    state_next = S_EL_FL;
                end
            end
            S_EL_FL: begin
                cmd.ld_f   = 1'b1;
                state_next = S_EL_RX;
            end
            S_EL_RX: begin
                rsel = sel_reg;
                rrow = kx;
                rcol = jx;
                cmd.rd_en  = 1'b1;
                state_next = S_EL_RY;
            end
            S_EL_RY: begin
                cmd.ld_a = 1'b1;
                rsel = sel_reg;
                rrow = ix;
                rcol = jx;
                cmd.rd_en  = 1'b1;
                state_next = S_EL_MUL;
            end
            S_EL_MUL: begin
                cmd.mul_start = 1'b1;
                state_next    = S_EL_MW;
            end
            S_EL_MW: begin
                if (stat.mul_done) begin
                    state_next = S_EL_WR;
                end
            end
            S_EL_WR: begin
                wsel = sel_reg;
                wrow = kx;
                wcol = jx;
                cmd.wr_en  = 1'b1;
                cmd.wr_src = SRC_SUB;
                if (step_end) begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_EL_F;
                end else begin
                    j_next     = step_j;
                    sel_next   = step_sel;
                    state_next = S_EL_RX;
                end
            end
            S_NEXT: begin
                if (i_reg + 1'b1 < n_eff) begin
                    i_next     = i_reg + 1'b1;
                    j_next     = i_reg + 1'b1;
                    state_next = S_PV_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_ld_solve = 1'b1;
                    cmd.out_status   = sing_reg;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        cmd.rd_addr  = elem_addr(rsel, rrow, rcol);
        cmd.rd_ident = cmd.rd_en && (rsel == SEL_INV) && !inv_valid_reg[{rrow, rcol}];
        cmd.rd_diag  = (rrow == rcol);
        cmd.wr_addr  = elem_addr(wsel, wrow, wcol);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            size_reg      <= 5'(MAX_N);
            out_valid_reg <= 1'b0;
            sing_reg      <= 1'b0;
            inv_valid_reg <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sing_reg      <= sing_next;
            if (cfg_we) begin
                size_reg <= cfg_wdata;
            end
            // identity load: drop the written marks of the n x n corner
            if (state_reg == S_INIT) begin
                for (int r = 0; r < MAX_N; r++) begin
                    for (int c = 0; c < MAX_N; c++) begin
                        if (r < int'(n_eff) && c < int'(n_eff)) begin
                            inv_valid_reg[r*MAX_N + c] <= 1'b0;
                        end
                    end
                end
            end else if (cmd.wr_en && wsel == SEL_INV) begin
                inv_valid_reg[{wrow, wcol}] <= 1'b1;
            end
        end
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        sel_reg <= sel_next;
        p_reg   <= p_next;
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE)
        else $error("request taken outside idle");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_ld_read || cmd.out_ld_solve) |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");

    a_div_before_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_NM_WR |-> $past(stat.div_done))
        else $error("quotient written before divider finished");

    a_mul_before_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EL_WR |-> stat.mul_done)
        else $error("difference written before product ready");

endmodule

`default_nettype wire

/* rtl/gauss_jordan_solve_invert.sv */
// Top level of the Gauss-Jordan solver/inverter: joins controller and
// datapath. Depends on gjsi_pkg, gjsi_ctrl and gjsi_dpath.
//
//  channel   dir  handshake           payload
//  s_        in   s_tvalid/s_tready   s_tuser: req_type; s_tdata: row, col, value
//  m_        out  m_tvalid/m_tready   m_tuser: status;   m_tdata: data
//  cfg_      in   cfg_we              cfg_wdata: matrix_size
//
// Write: taken on acceptance. Read: the element RAM's registered read, then the result register.
// Solve time is set by the one shared multiply-subtract sequence, used for
// each element, and the
// bit-serial divider (72 steps per pivot-row element).
// Reset is synchronous and needs no clearing pass; a waiting result holds
// until taken, and a read or solve result waits for a free result register.
`default_nettype none

module gauss_jordan_solve_invert (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    input  wire logic [63:0] s_tdata,   // [3:0] row, [8:4] col, [56:9] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [0:0]       m_tuser,   // [0] status
    output logic [47:0]      m_tdata,   // [47:0] data
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata
);
    import gjsi_pkg::*;

    dp_cmd_t              cmd;
    dp_stat_t             stat;
    logic signed [VW-1:0] out_data;
    logic                 out_status;

    gjsi_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_req    (s_tuser),
        .in_row    (s_tdata[3:0]),
        .in_col    (s_tdata[8:4]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    gjsi_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_value   ($signed(s_tdata[56:9])),
        .stat       (stat),
        .out_data   (out_data),
        .out_status (out_status)
    );

    assign m_tdata    = out_data;
    assign m_tuser[0] = out_status;

endmodule

`default_nettype wire
